FILE: src/rks_pkg.sv
// Shared types and constants for the range k-th smallest block.
package rks_pkg;

  localparam int SHELF_W = 11;
  localparam int OPND_W  = 16;
  localparam int VALUE_W = 16;

  typedef logic [SHELF_W-1:0] shelf_t;

  localparam shelf_t SHELF_COUNT_RST = 11'd1024;

  localparam logic MODE_QUERY  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic               mode;
    shelf_t             first_shelf;
    shelf_t             last_shelf;
    logic [OPND_W-1:0]  operand;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] kth_value;
    logic               status;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } sel_state_t;

endpackage

FILE: src/rks_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
interface rks_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/rks_mem.sv
// Single-port count table, synchronous write, registered read.
module rks_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] ram [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      ram[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= ram[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/rks_ctrl.sv
// Item decode, update writes and bitwise radix selection over the table.
module rks_ctrl #(
  parameter int COUNT_WIDTH = 16,
  parameter int AW          = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rks_pkg::shelf_t      in_use,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rks_pkg::in_item_t    in_item,
  output logic                 res_valid,
  input  logic                 res_take,
  output rks_pkg::out_item_t   res_item,
  output logic                 mem_we,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_addr,
  output logic [COUNT_WIDTH-1:0] mem_wdata,
  input  logic [COUNT_WIDTH-1:0] mem_rdata
);
  import rks_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int BW = (CW > 1) ? $clog2(CW) : 1;
  localparam int IW = (AW > SHELF_W) ? AW : SHELF_W;
  localparam int PW = (CW > VALUE_W) ? CW : VALUE_W;
  localparam int OW = (CW > OPND_W) ? CW : OPND_W;

  sel_state_t          state_r, state_nxt;
  logic [AW-1:0]       lo_r, lo_nxt;
  logic [AW-1:0]       hi_r, hi_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic                issue_r, issue_nxt;
  logic                dv_r, dv_nxt;
  logic                dl_r, dl_nxt;
  logic [SHELF_W-1:0]  zeros_r, zeros_nxt;
  logic [OPND_W-1:0]   k_r, k_nxt;
  logic [CW-1:0]       prefix_r, prefix_nxt;
  logic [BW-1:0]       bit_r, bit_nxt;
  out_item_t           res_r, res_nxt;

  logic                accept;
  logic                is_update;
  logic                upd_ok;
  logic                qry_ok;
  logic [SHELF_W:0]    range_len;
  logic [IW-1:0]       first_idx;
  logic [IW-1:0]       last_idx;
  logic [OW-1:0]       opnd_wide;
  logic [CW-1:0]       high_mask;
  logic [CW-1:0]       bit_sel;
  logic                match;
  logic [SHELF_W-1:0]  total;
  logic                pass_end;
  logic                take_one;
  logic [CW-1:0]       prefix_fin;
  logic [PW-1:0]       prefix_wide;

  assign accept    = in_valid && in_ready;
  assign is_update = (in_item.mode == MODE_UPDATE);
  assign range_len = {1'b0, in_item.last_shelf} - {1'b0, in_item.first_shelf} + 12'd1;
  assign first_idx = IW'(in_item.first_shelf) - IW'(1);
  assign last_idx  = IW'(in_item.last_shelf) - IW'(1);
  assign opnd_wide = OW'(in_item.operand);

  assign upd_ok = (in_item.first_shelf != '0) && (in_item.first_shelf <= in_use);
  assign qry_ok = (in_item.first_shelf != '0)
               && (in_item.first_shelf <= in_item.last_shelf)
               && (in_item.last_shelf <= in_use)
               && (in_item.operand != '0)
               && (in_item.operand <= OPND_W'(range_len));

  // bits at and above the current bit must equal the prefix found so far
  assign high_mask = {CW{1'b1}} << bit_r;
  assign bit_sel   = CW'(1) << bit_r;
  assign match     = dv_r && ((mem_rdata & high_mask) == prefix_r);
  assign total     = zeros_r + SHELF_W'(match);
  assign pass_end  = dv_r && dl_r;
  assign take_one  = k_r > OPND_W'(total);
  assign prefix_fin  = take_one ? (prefix_r | bit_sel) : prefix_r;
  assign prefix_wide = PW'(prefix_fin);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !is_update) begin
          state_nxt = qry_ok ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (pass_end && bit_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    addr_nxt   = addr_r;
    issue_nxt  = issue_r;
    dv_nxt     = 1'b0;
    dl_nxt     = 1'b0;
    zeros_nxt  = zeros_r;
    k_nxt      = k_r;
    prefix_nxt = prefix_r;
    bit_nxt    = bit_r;
    res_nxt    = res_r;
    in_ready   = (state_r == ST_IDLE);
    res_valid  = (state_r == ST_EMIT);
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = addr_r;
    mem_wdata  = opnd_wide[CW-1:0];

    case (state_r)
      ST_IDLE: begin
        mem_addr = first_idx[AW-1:0];
        if (accept && is_update) begin
          mem_we = upd_ok;
        end
        if (accept && !is_update) begin
          lo_nxt     = first_idx[AW-1:0];
          hi_nxt     = last_idx[AW-1:0];
          addr_nxt   = first_idx[AW-1:0];
          issue_nxt  = qry_ok;
          zeros_nxt  = '0;
          k_nxt      = in_item.operand;
          prefix_nxt = '0;
          bit_nxt    = BW'(CW - 1);
          res_nxt.kth_value = '0;
          res_nxt.status    = STATUS_BAD;
        end
      end
      ST_SCAN: begin
        mem_re = issue_r;
        dv_nxt = issue_r;
        dl_nxt = issue_r && (addr_r == hi_r);
        if (issue_r) begin
          if (addr_r == hi_r) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + AW'(1);
          end
        end
        if (pass_end) begin
          zeros_nxt  = '0;
          prefix_nxt = prefix_fin;
          if (take_one) begin
            k_nxt = k_r - OPND_W'(total);
          end
          if (bit_r == '0) begin
            res_nxt.kth_value = prefix_wide[VALUE_W-1:0];
            res_nxt.status    = STATUS_OK;
          end else begin
            bit_nxt   = bit_r - BW'(1);
            addr_nxt  = lo_r;
            issue_nxt = 1'b1;
          end
        end else begin
          zeros_nxt = total;
        end
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  assign res_item = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      issue_r <= 1'b0;
      dv_r    <= 1'b0;
      dl_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
      dv_r    <= dv_nxt;
      dl_r    <= dl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    addr_r   <= addr_nxt;
    zeros_r  <= zeros_nxt;
    k_r      <= k_nxt;
    prefix_r <= prefix_nxt;
    bit_r    <= bit_nxt;
    res_r    <= res_nxt;
  end

endmodule

FILE: src/range_kth_smallest_with_update.sv
// Range k-th smallest shelf count with point update: top level.
//
// Channels: in_chan takes items (mode, first_shelf, last_shelf, operand);
// an update (mode 1) writes one shelf count and returns nothing, a query
// (mode 0) returns one transaction on out_chan (kth_value, status).
// cfg_chan writes shelf_count (shelves in use) and is always ready; write
// it only while no query is in flight.
// An update is written as it is taken, and a bad query answers without a
// scan. A good query makes one pass per count bit: one table read per shelf
// on the single memory port, whose reads are registered.
// Items are taken one at a time; in_chan.ready is low during a scan and
// while an answer waits for room in the output register.
// Reset: shelf_count returns to 1024 and the engine idles; the count
// table is not cleared, so shelves must be written before they are read.
// A stalled receiver holds out_chan; one more answer may wait inside.
module range_kth_smallest_with_update #(
  parameter int MAX_SHELVES = 1024,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  rks_chan_if.sink          in_chan,
  rks_chan_if.source        out_chan,
  rks_chan_if.sink          cfg_chan
);
  import rks_pkg::*;

  localparam int AW = $clog2(MAX_SHELVES);

  shelf_t              shelf_count_r;
  shelf_t              in_use;
  logic                out_vld_r;
  out_item_t           out_data_r;
  logic                res_valid;
  logic                res_take;
  out_item_t           res_item;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_addr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [COUNT_WIDTH-1:0] mem_rdata;

  assign cfg_chan.ready = 1'b1;
  assign in_use = (32'(shelf_count_r) < MAX_SHELVES) ? shelf_count_r
                                                      : SHELF_W'(MAX_SHELVES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shelf_count_r <= SHELF_COUNT_RST;
    end else if (cfg_chan.valid) begin
      shelf_count_r <= cfg_chan.payload;
    end
  end

  // output register: refill when empty or being drained
  assign res_take = !out_vld_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_take) begin
      out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data_r <= res_item;
    end
  end

  assign out_chan.valid   = out_vld_r;
  assign out_chan.payload = out_data_r;

  rks_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_use    (in_use),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_item   (in_chan.payload),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_item  (res_item),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  rks_mem #(
    .DEPTH (MAX_SHELVES),
    .AW    (AW),
    .DW    (COUNT_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
